>>> sv/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg - shared types and constants for the bitmap page allocator
// Sizes of the map, request codes, sequencer states and word unit controls.
// ----------------------------------------------------------------------------
package bpa_pkg;

   localparam int MAP_PAGES  = 256;
   localparam int PAGE_BYTES = 4096;
   localparam int WORD_BITS  = 32;
   localparam int MAP_WORDS  = (MAP_PAGES + WORD_BITS - 1) / WORD_BITS;

   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int WIDX_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int COUNT_W    = 9;              // free_pages_left field
   localparam int PAGE_W     = 8;              // page_number / granted_page fields
   localparam int MODE_W     = 2;
   localparam int ADDR_W     = 20;             // os_last_address register
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int START_W    = ADDR_W + 1 - PAGE_SHIFT;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register index, taken from the word address bits of paddr
   localparam logic [CSR_ADDR_W-3:0] REG_OS_LAST_ADDRESS = '0;

   typedef enum logic [MODE_W-1:0] {
      MODE_INIT  = 2'd0,
      MODE_ALLOC = 2'd1,
      MODE_FREE  = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_SCAN,
      ST_FREE,
      ST_REPLY
   } state_type;

   typedef enum logic [1:0] {
      UOP_FILL,      // build the init pattern for one word
      UOP_TAKE,      // find lowest set bit and clear it
      UOP_SET        // set one bit
   } unit_op_type;

   typedef struct packed {
      unit_op_type        op;
      logic [COUNT_W-1:0] start;
      logic [WIDX_W-1:0]  widx;
      logic [BIT_W-1:0]   bit_idx;
   } unit_req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] word;
      logic                 found;
      logic [BIT_W-1:0]     bit_idx;
   } unit_rsp_type;

endpackage

>>> sv/bpa_if.sv
// ----------------------------------------------------------------------------
// bpa_req_if / bpa_rsp_if - request and response channels
// Valid/ready channels carrying one allocator request or one result item.
// ----------------------------------------------------------------------------
interface bpa_req_if;
   import bpa_pkg::*;

   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [PAGE_W-1:0] page_number;

   modport source (output valid, mode, page_number, input ready);
   modport sink   (input valid, mode, page_number, output ready);
endinterface

interface bpa_rsp_if;
   import bpa_pkg::*;

   logic               valid;
   logic               ready;
   logic [PAGE_W-1:0]  granted_page;
   logic               success;
   logic [COUNT_W-1:0] free_pages_left;

   modport source (output valid, granted_page, success, free_pages_left, input ready);
   modport sink   (input valid, granted_page, success, free_pages_left, output ready);
endinterface

>>> sv/bpa_word_unit.sv
// ----------------------------------------------------------------------------
// bpa_word_unit - shared map word unit
// Works on one 32-bit map word: init fill pattern, lowest-free take, bit set.
// ----------------------------------------------------------------------------
module bpa_word_unit (
   input  bpa_pkg::unit_req_type           ctrl,
   input  logic [bpa_pkg::WORD_BITS-1:0]   word_in,
   output bpa_pkg::unit_rsp_type           result
);
   import bpa_pkg::*;

   logic [COUNT_W-1:0]   base;
   logic [WORD_BITS-1:0] fill;
   logic                 found;
   logic [BIT_W-1:0]     low_bit;

   assign base = COUNT_W'({ctrl.widx, {BIT_W{1'b0}}});

   // free for start <= page < MAP_PAGES
   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         fill[b] = ((base + COUNT_W'(b)) >= ctrl.start) &&
                   ((base + COUNT_W'(b)) < COUNT_W'(MAP_PAGES));
      end
   end

   // lowest set bit
   always_comb begin
      found   = 1'b0;
      low_bit = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (word_in[b]) begin
            found   = 1'b1;
            low_bit = BIT_W'(b);
         end
      end
   end

   always_comb begin
      result.found   = found;
      result.bit_idx = low_bit;
      case (ctrl.op)
         UOP_FILL: begin
            result.word = fill;
         end
         UOP_TAKE: begin
            result.word = word_in & ~(WORD_BITS'(1) << low_bit);
         end
         UOP_SET: begin
            result.word = word_in | (WORD_BITS'(1) << ctrl.bit_idx);
         end
         default: begin
            result.word = word_in;
         end
      endcase
   end

endmodule

>>> sv/bpa_core.sv
// ----------------------------------------------------------------------------
// bpa_core - allocator sequencer, free map and result register
// Walks the map one word a cycle through the shared word unit.
// ----------------------------------------------------------------------------
module bpa_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bpa_pkg::MODE_W-1:0]    req_mode,
   input  logic [bpa_pkg::PAGE_W-1:0]    req_page,
   input  logic [bpa_pkg::ADDR_W-1:0]    os_last_address,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bpa_pkg::PAGE_W-1:0]    rsp_page,
   output logic                          rsp_success,
   output logic [bpa_pkg::COUNT_W-1:0]   rsp_count
);
   import bpa_pkg::*;

   state_type            state_ff, state_in;
   logic [WORD_BITS-1:0] map_ff [MAP_WORDS];
   logic [WIDX_W-1:0]    widx_ff, widx_in;
   logic [BIT_W-1:0]     bit_ff, bit_in;
   logic [COUNT_W-1:0]   start_ff, start_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 res_ok_ff, res_ok_in;
   logic [PAGE_W-1:0]    res_page_ff, res_page_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 out_ok_ff;
   logic [PAGE_W-1:0]    out_page_ff;
   logic [COUNT_W-1:0]   out_count_ff;

   logic                 accept;
   logic                 last_word;
   logic                 slot_free;
   logic                 map_we;
   logic [ADDR_W:0]      round_sum;
   logic [START_W-1:0]   start_raw;
   unit_req_type         unit_ctrl;
   unit_rsp_type         unit_res;

   assign accept    = req_valid && req_ready;
   assign last_word = (widx_ff == WIDX_W'(MAP_WORDS - 1));
   assign slot_free = !out_valid_ff || rsp_ready;

   // first allocatable page, clamped to the page total
   assign round_sum = {1'b0, os_last_address} + (ADDR_W + 1)'(PAGE_BYTES - 4);
   assign start_raw = round_sum[ADDR_W:PAGE_SHIFT];
   assign start_in  = (start_raw >= START_W'(MAP_PAGES)) ? COUNT_W'(MAP_PAGES)
                                                         : COUNT_W'(start_raw);

   always_comb begin
      unit_ctrl.start   = start_ff;
      unit_ctrl.widx    = widx_ff;
      unit_ctrl.bit_idx = bit_ff;
      case (state_ff)
         ST_INIT: unit_ctrl.op = UOP_FILL;
         ST_SCAN: unit_ctrl.op = UOP_TAKE;
         default: unit_ctrl.op = UOP_SET;
      endcase
   end

   bpa_word_unit u_word_unit (
      .ctrl    (unit_ctrl),
      .word_in (map_ff[widx_ff]),
      .result  (unit_res)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_mode)
                  MODE_INIT:  state_in = ST_INIT;
                  MODE_ALLOC: state_in = ST_SCAN;
                  MODE_FREE:  state_in = (32'(req_page) < MAP_PAGES) ? ST_FREE : ST_REPLY;
                  default:    state_in = ST_REPLY;
               endcase
            end
         end
         ST_INIT: begin
            if (last_word) state_in = ST_REPLY;
         end
         ST_SCAN: begin
            if (unit_res.found || last_word) state_in = ST_REPLY;
         end
         ST_FREE: begin
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      widx_in      = widx_ff;
      bit_in       = bit_ff;
      count_in     = count_ff;
      res_ok_in    = res_ok_ff;
      res_page_in  = res_page_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      map_we       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_ok_in   = 1'b0;
               res_page_in = '0;
               widx_in     = '0;
               if (req_mode == MODE_FREE) begin
                  widx_in = WIDX_W'(req_page >> BIT_W);
                  bit_in  = req_page[BIT_W-1:0];
               end
            end
         end
         ST_INIT: begin
            map_we  = 1'b1;
            widx_in = widx_ff + 1'b1;
            if (last_word) begin
               count_in  = COUNT_W'(MAP_PAGES) - start_ff;
               res_ok_in = 1'b1;
            end
         end
         ST_SCAN: begin
            widx_in = widx_ff + 1'b1;
            if (unit_res.found) begin
               map_we      = 1'b1;
               res_ok_in   = 1'b1;
               res_page_in = PAGE_W'({widx_ff, unit_res.bit_idx});
               if (count_ff != '0) count_in = count_ff - 1'b1;
            end
         end
         ST_FREE: begin
            map_we    = 1'b1;
            res_ok_in = 1'b1;
            if (count_ff < COUNT_W'(MAP_PAGES)) count_in = count_ff + 1'b1;
         end
         ST_REPLY: begin
            if (slot_free) out_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
         for (int w = 0; w < MAP_WORDS; w++) map_ff[w] <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
         if (map_we) map_ff[widx_ff] <= unit_res.word;
      end
   end

   always_ff @(posedge clock) begin
      widx_ff     <= widx_in;
      bit_ff      <= bit_in;
      res_ok_ff   <= res_ok_in;
      res_page_ff <= res_page_in;
      if (accept) start_ff <= start_in;
      if (state_ff == ST_REPLY && slot_free) begin
         out_ok_ff    <= res_ok_ff;
         out_page_ff  <= res_page_ff;
         out_count_ff <= count_ff;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_success = out_ok_ff;
   assign rsp_page    = out_page_ff;
   assign rsp_count   = out_count_ff;

endmodule

>>> sv/bitmap_page_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator - lowest-first physical page allocator
// Free bitmap of 32-bit words with a free-page count and an APB config port.
// ----------------------------------------------------------------------------
// One request at a time. After the accept cycle an init walks all map words,
// one a cycle, an allocate scans words from page 0 up and stops at the first
// nonzero word, and a free is a single read-modify-write of one map word;
// the reply state then moves the item into the result register once that
// register is free. The map word loop runs through the single word unit.
// req ready is high only while the sequencer is idle; a finished result
// waiting in the output register does not hold it off.
// An allocate on an empty map reports success 0 and page 0.
// os_last_address is at byte address 0 and should only be written while
// the block is idle.
module bitmap_page_allocator (
   input  logic                             clock,
   input  logic                             reset,
   bpa_req_if.sink                          req_ch,
   bpa_rsp_if.source                        rsp_ch,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [bpa_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [bpa_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [bpa_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import bpa_pkg::*;

   logic [ADDR_W-1:0]     os_last_ff;
   logic                  csr_write;
   logic [CSR_ADDR_W-3:0] csr_index;

   // --- config port: zero wait state ---
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         os_last_ff <= '0;
      end else if (csr_write && csr_index == REG_OS_LAST_ADDRESS) begin
         os_last_ff <= csr_pwdata[ADDR_W-1:0];
      end
   end

   // unmapped addresses read as zero
   always_comb begin
      csr_prdata = '0;
      if (csr_index == REG_OS_LAST_ADDRESS) csr_prdata = CSR_DATA_W'(os_last_ff);
   end

   // --- allocator ---
   bpa_core u_core (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ch.ready),
      .req_mode        (req_ch.mode),
      .req_page        (req_ch.page_number),
      .os_last_address (os_last_ff),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_page        (rsp_ch.granted_page),
      .rsp_success     (rsp_ch.success),
      .rsp_count       (rsp_ch.free_pages_left)
   );

endmodule

>>> sv/bpa_checker.sv
// ----------------------------------------------------------------------------
// bpa_checker - port-level checks for the bitmap page allocator
// Watches the request and result channels; bound to the top level.
// ----------------------------------------------------------------------------
module bpa_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [bpa_pkg::PAGE_W-1:0]     granted_page,
   input logic                           success,
   input logic [bpa_pkg::COUNT_W-1:0]    free_pages_left
);
   import bpa_pkg::*;

   // a held result stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before taken");

   // one request at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_fail_page_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !success |-> granted_page == '0)
      else $error("failed item carries a page");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> free_pages_left <= COUNT_W'(MAP_PAGES))
      else $error("free count above page total");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .granted_page    (rsp_ch.granted_page),
   .success         (rsp_ch.success),
   .free_pages_left (rsp_ch.free_pages_left)
);

>>> dv/bitmap_page_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_page_allocator_tb - self-checking bench for the page allocator
// A table of directed requests runs first, then phases of random requests.
// Each phase writes os_last_address, inits the map and mixes allocates,
// frees (mostly of handed-out pages), inits and no-op requests. Every result
// is checked against the table or a local copy of the free map and count.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_tb;
   import bpa_pkg::*;

   // mode 3 is not a legal request; the block must answer it as a no-op
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS = 1400;
   localparam int BUSY_PCT     = 35;

   typedef struct packed {
      logic [PAGE_W-1:0]  granted;
      logic               ok;
      logic [COUNT_W-1:0] left;
   } page_result_type;

   // one line of the directed table: either a register write or a request
   typedef struct packed {
      logic               is_cfg;
      logic [ADDR_W-1:0]  cfg_val;
      logic [MODE_W-1:0]  mode;
      logic [PAGE_W-1:0]  page;
      logic               typed;    // expected result given in the table
      page_result_type    result;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   bpa_req_if req_if ();
   bpa_rsp_if rsp_if ();

   bitmap_page_allocator dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // local copy of the allocator state
   logic [WORD_BITS-1:0] free_map [MAP_WORDS];
   logic [COUNT_W-1:0]   free_count;
   logic [ADDR_W-1:0]    os_last;

   page_result_type   pending_results [$];
   table_row_type     directed_rows [$];
   logic [PAGE_W-1:0] held_pages [$];    // pages granted and not yet freed

   int error_count = 0;
   int items_sent  = 0;
   int busy_pct    = BUSY_PCT;           // shared by sender and receiver

   // Work out the result of one request and update the local state.
   function automatic page_result_type next_allocator_result(
      input logic [MODE_W-1:0] mode,
      input logic [PAGE_W-1:0] page
   );
      page_result_type res;
      int              first_page;
      int              lowest;
      bit              found;
      res = '0;
      case (mode)
         MODE_INIT: begin
            // first page past the OS image, last address rounded up
            first_page = (int'(os_last) + PAGE_BYTES - 4) / PAGE_BYTES;
            for (int w = 0; w < MAP_WORDS; w++) free_map[w] = '0;
            free_count = '0;
            for (int p = first_page; p < MAP_PAGES; p++) begin
               free_map[p / WORD_BITS][p % WORD_BITS] = 1'b1;
               free_count = free_count + 1'b1;
            end
            res.ok = 1'b1;
         end
         MODE_ALLOC: begin
            found = 1'b0;
            for (int w = 0; w < MAP_WORDS; w++) begin
               if (!found && free_map[w] != '0) begin
                  lowest = 0;
                  for (int b = WORD_BITS - 1; b >= 0; b--)
                     if (free_map[w][b]) lowest = b;
                  free_map[w][lowest] = 1'b0;
                  res.granted = PAGE_W'(w * WORD_BITS + lowest);
                  // count may run ahead of the map after double frees
                  if (free_count != '0) free_count = free_count - 1'b1;
                  res.ok = 1'b1;
                  found = 1'b1;
               end
            end
         end
         MODE_FREE: begin
            if (int'(page) < MAP_PAGES) begin
               free_map[int'(page) / WORD_BITS][int'(page) % WORD_BITS] = 1'b1;
               if (int'(free_count) < MAP_PAGES) free_count = free_count + 1'b1;
               res.ok = 1'b1;
            end
         end
         default: ;
      endcase
      res.left = free_count;
      return res;
   endfunction

   task automatic add_row(input logic is_cfg, input logic [ADDR_W-1:0] cfg_val,
                          input logic [MODE_W-1:0] mode, input logic [PAGE_W-1:0] page,
                          input logic typed, input logic [PAGE_W-1:0] granted,
                          input logic ok, input logic [COUNT_W-1:0] left);
      table_row_type row;
      row.is_cfg         = is_cfg;
      row.cfg_val        = cfg_val;
      row.mode           = mode;
      row.page           = page;
      row.typed          = typed;
      row.result.granted = granted;
      row.result.ok      = ok;
      row.result.left    = left;
      directed_rows.push_back(row);
   endtask

   // Present one item, hold it until taken, then queue its expected result.
   task automatic send_request(input logic [MODE_W-1:0] mode,
                               input logic [PAGE_W-1:0] page,
                               input logic typed, input page_result_type typed_res);
      page_result_type res;
      while ($urandom_range(0, 99) < busy_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.mode        <= mode;
      req_if.page_number <= page;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      // taken at this edge
      res = next_allocator_result(mode, page);
      pending_results.push_back(typed ? typed_res : res);
      items_sent++;
      if (mode == MODE_INIT) held_pages.delete();
      if (mode == MODE_ALLOC && res.ok) held_pages.push_back(res.granted);
   endtask

   // Register write, only with the block drained: every item has a result,
   // so an empty expectation queue means the sequencer is idle.
   task automatic write_os_last(input logic [ADDR_W-1:0] value);
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {REG_OS_LAST_ADDRESS, 2'b00};
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      os_last = value;
   endtask

   // Receiver: random stalls, checks each taken result against the oldest
   // expectation.
   always @(posedge clock) begin
      page_result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result page %0d success %0d left %0d", $time,
                        rsp_if.granted_page, rsp_if.success, rsp_if.free_pages_left);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_if.granted_page !== want.granted) begin
                  $display("%0t: granted_page expected %0d actual %0d", $time,
                           want.granted, rsp_if.granted_page);
                  error_count++;
               end
               if (rsp_if.success !== want.ok) begin
                  $display("%0t: success expected %0d actual %0d", $time,
                           want.ok, rsp_if.success);
                  error_count++;
               end
               if (rsp_if.free_pages_left !== want.left) begin
                  $display("%0t: free_pages_left expected %0d actual %0d", $time,
                           want.left, rsp_if.free_pages_left);
                  error_count++;
               end
            end
         end
         rsp_if.ready <= ($urandom_range(0, 99) >= busy_pct);
      end
   end

   // Main sequence
   initial begin
      table_row_type     row;
      logic [ADDR_W-1:0] os_val;
      logic [MODE_W-1:0] mode;
      logic [PAGE_W-1:0] page;
      int                phase;
      int                phase_len;
      int                start_page;
      int                pick;
      int                roll;

      req_if.valid       <= 1'b0;
      req_if.mode        <= MODE_INIT;
      req_if.page_number <= '0;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= '0;
      csr_pwdata         <= '0;

      for (int w = 0; w < MAP_WORDS; w++) free_map[w] = '0;
      free_count = '0;
      os_last    = '0;

      // Directed table. After reset the map is empty and os_last_address is 0.
      add_row(0, 0, MODE_ALLOC,  8'h00, 1, 8'd0,   1'b0, 9'd0);   // empty map
      add_row(0, 0, MODE_UNUSED, 8'hFF, 1, 8'd0,   1'b0, 9'd0);   // no-op mode
      add_row(0, 0, MODE_FREE,   8'hFF, 1, 8'd0,   1'b1, 9'd1);   // top page
      add_row(0, 0, MODE_FREE,   8'hFF, 1, 8'd0,   1'b1, 9'd2);   // double free
      add_row(0, 0, MODE_ALLOC,  8'h00, 1, 8'd255, 1'b1, 9'd1);
      add_row(0, 0, MODE_ALLOC,  8'h00, 1, 8'd0,   1'b0, 9'd1);   // count ahead of map
      add_row(0, 0, MODE_INIT,   8'h00, 1, 8'd0,   1'b1, 9'd256); // whole map free
      add_row(0, 0, MODE_ALLOC,  8'h00, 1, 8'd0,   1'b1, 9'd255);
      add_row(0, 0, MODE_FREE,   8'h00, 1, 8'd0,   1'b1, 9'd256);
      add_row(0, 0, MODE_FREE,   8'h00, 1, 8'd0,   1'b1, 9'd256); // count saturates
      add_row(0, 0, MODE_ALLOC,  8'h00, 1, 8'd0,   1'b1, 9'd255);
      add_row(0, 0, MODE_ALLOC,  8'hFF, 0, 8'd0,   1'b0, 9'd0);
      add_row(0, 0, MODE_FREE,   8'hAA, 0, 8'd0,   1'b0, 9'd0);
      // OS image past the top: init leaves nothing free
      add_row(1, 20'hFFFFF, MODE_INIT, 8'h00, 0, 8'd0, 1'b0, 9'd0);
      add_row(0, 0, MODE_INIT,   8'h00, 1, 8'd0,   1'b1, 9'd0);
      add_row(0, 0, MODE_ALLOC,  8'h00, 1, 8'd0,   1'b0, 9'd0);
      add_row(0, 0, MODE_FREE,   8'h55, 1, 8'd0,   1'b1, 9'd1);
      add_row(0, 0, MODE_ALLOC,  8'h00, 1, 8'h55,  1'b1, 9'd0);
      // first free page is the last one
      add_row(1, 20'hFE004, MODE_INIT, 8'h00, 0, 8'd0, 1'b0, 9'd0);
      add_row(0, 0, MODE_INIT,   8'h00, 1, 8'd0,   1'b1, 9'd1);
      add_row(0, 0, MODE_ALLOC,  8'h00, 1, 8'd255, 1'b1, 9'd0);
      add_row(0, 0, MODE_ALLOC,  8'h00, 1, 8'd0,   1'b0, 9'd0);
      // rounding: address 4 starts at page 1, address 3 at page 0
      add_row(1, 20'd4, MODE_INIT, 8'h00, 0, 8'd0, 1'b0, 9'd0);
      add_row(0, 0, MODE_INIT,   8'h00, 1, 8'd0,   1'b1, 9'd255);
      add_row(0, 0, MODE_ALLOC,  8'h00, 1, 8'd1,   1'b1, 9'd254);
      add_row(1, 20'd3, MODE_INIT, 8'h00, 0, 8'd0, 1'b0, 9'd0);
      add_row(0, 0, MODE_INIT,   8'h00, 0, 8'd0,   1'b0, 9'd0);
      add_row(0, 0, MODE_ALLOC,  8'h00, 0, 8'd0,   1'b0, 9'd0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         if (row.is_cfg) write_os_last(row.cfg_val);
         else send_request(row.mode, row.page, row.typed, row.result);
      end

      // Random phases: new os_last_address, init, then a mix of requests.
      phase = 0;
      while (items_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 5))
            0: os_val = '0;
            1: os_val = 20'hFFFFF;
            2: os_val = ADDR_W'($urandom());
            3: begin
               // small pool near the top so allocates run the map dry
               start_page = $urandom_range(200, 255);
               os_val = ADDR_W'((start_page - 1) * PAGE_BYTES + 4 + $urandom_range(0, 4095));
            end
            4: begin
               start_page = $urandom_range(1, 255);
               os_val = ADDR_W'((start_page - 1) * PAGE_BYTES + 4 + $urandom_range(0, 4095));
            end
            default: os_val = ADDR_W'($urandom_range(0, 4));
         endcase
         write_os_last(os_val);

         // one phase without any stalls on either side
         busy_pct = (phase == 1) ? 0 : BUSY_PCT;
         send_request(MODE_INIT, PAGE_W'($urandom()), 1'b0, '0);
         phase_len = $urandom_range(40, 250);
         for (int k = 0; k < phase_len; k++) begin
            roll = $urandom_range(0, 99);
            page = PAGE_W'($urandom());
            if (roll < 48) begin
               mode = MODE_ALLOC;
            end else if (roll < 88) begin
               mode = MODE_FREE;
               // mostly give back a page we hold; otherwise any page
               if (held_pages.size() != 0 && $urandom_range(0, 99) < 80) begin
                  pick = $urandom_range(0, held_pages.size() - 1);
                  page = held_pages[pick];
                  held_pages.delete(pick);
               end
            end else if (roll < 94) begin
               mode = MODE_INIT;
            end else begin
               mode = MODE_UNUSED;
            end
            send_request(mode, page, 1'b0, '0);
         end
         phase++;
      end

      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog, well past the slowest legal run
   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
